>>> hdl/lzrtp_pkg.sv
// package for the lz reference token parser
// word types, token kinds and character codes; no dependencies
`default_nettype none

package lzrtp_pkg;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  token_kind;
      logic [7:0]  literal_value;
      logic [31:0] ref_source;
      logic [31:0] ref_count;
      logic [31:0] header_length;
   } rsp_type;

   localparam logic [1:0] KIND_HDR = 2'd0;
   localparam logic [1:0] KIND_LIT = 2'd1;
   localparam logic [1:0] KIND_REF = 2'd2;
   localparam logic [1:0] KIND_ERR = 2'd3;

   localparam logic [7:0] CH_OPEN  = 8'h7B;
   localparam logic [7:0] CH_CLOSE = 8'h7D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

endpackage

`default_nettype wire

>>> hdl/lzrtp_digit.sv
// decimal digit accumulate: acc * 10 + digit with overflow flag
// no package dependency
`default_nettype none

module lzrtp_digit #(
   parameter int POSITION_BITS = 32
) (
   input  wire logic [POSITION_BITS-1:0] acc,
   input  wire logic [7:0]               code_byte,
   output logic      [POSITION_BITS-1:0] sum,
   output logic                          overflow
);

   logic [POSITION_BITS+3:0] acc_x;
   logic [POSITION_BITS+3:0] total;

   always_comb begin
      acc_x = {4'b0, acc};
      // ascii digits carry their value in the low nibble
      total = (acc_x << 3) + (acc_x << 1) + {{POSITION_BITS{1'b0}}, code_byte[3:0]};
      sum = total[POSITION_BITS-1:0];
      overflow = |total[POSITION_BITS+3:POSITION_BITS];
   end

endmodule

`default_nettype wire

>>> hdl/lzrtp_parse.sv
// parse state machine: phase, number accumulator, held source, text length
// uses lzrtp_pkg and lzrtp_digit
`default_nettype none

module lzrtp_parse #(
   parameter int POSITION_BITS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire lzrtp_pkg::req_type word,
   output lzrtp_pkg::rsp_type    tok,
   output logic                  tok_valid
);

   import lzrtp_pkg::*;

   localparam logic [2:0] PH_HDR  = 3'd0;
   localparam logic [2:0] PH_BODY = 3'd1;
   localparam logic [2:0] PH_OPEN = 3'd2;
   localparam logic [2:0] PH_SRC  = 3'd3;
   localparam logic [2:0] PH_NUM  = 3'd4;
   localparam logic [2:0] PH_ERR  = 3'd5;

   localparam logic [POSITION_BITS-1:0] POS_ZERO = '0;
   localparam logic [POSITION_BITS-1:0] POS_ONE  = POSITION_BITS'(1);

   logic [2:0]               phase_ff, phase_in;
   logic [POSITION_BITS-1:0] acc_ff, acc_in;
   logic [POSITION_BITS-1:0] src_ff, src_in;
   logic [POSITION_BITS-1:0] len_ff, len_in;

   logic [POSITION_BITS-1:0] acc_base;
   logic [POSITION_BITS-1:0] dig_sum;
   logic                     dig_ovf;
   logic                     is_dig;
   logic                     err;

   function automatic logic [31:0] fit32(input logic [POSITION_BITS-1:0] v);
      logic [POSITION_BITS+31:0] ext;
      ext = {32'b0, v};
      return ext[31:0];
   endfunction

   // a reference number restarts from zero on its first digit
   assign acc_base = (phase_ff == PH_OPEN) ? POS_ZERO : acc_ff;

   lzrtp_digit #(
      .POSITION_BITS(POSITION_BITS)
   ) u_digit (
      .acc      (acc_base),
      .code_byte(word.code_byte),
      .sum      (dig_sum),
      .overflow (dig_ovf)
   );

   always_comb begin
      is_dig    = (word.code_byte >= CH_ZERO) && (word.code_byte <= CH_NINE);
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      src_in    = src_ff;
      len_in    = len_ff;
      err       = 1'b0;
      tok_valid = 1'b0;
      tok       = '0;

      unique case (phase_ff)
         PH_HDR: begin
            if (is_dig) begin
               if (dig_ovf) err = 1'b1;
               else acc_in = dig_sum;
            end else if (word.code_byte == CH_COLON) begin
               len_in = acc_ff;
               acc_in = POS_ZERO;
               tok.token_kind = KIND_HDR;
               tok.header_length = fit32(acc_ff);
               tok_valid = 1'b1;
               phase_in = PH_BODY;
            end else begin
               err = 1'b1;
            end
         end
         PH_BODY: begin
            if (word.code_byte == CH_OPEN) begin
               phase_in = PH_OPEN;
            end else begin
               tok.token_kind = KIND_LIT;
               tok.literal_value = word.code_byte;
               tok_valid = 1'b1;
            end
         end
         PH_OPEN: begin
            if (word.code_byte == CH_OPEN) begin
               tok.token_kind = KIND_LIT;
               tok.literal_value = word.code_byte;
               tok_valid = 1'b1;
               phase_in = PH_BODY;
            end else if (is_dig) begin
               if (dig_ovf) err = 1'b1;
               else acc_in = dig_sum;
               phase_in = PH_SRC;
            end else begin
               err = 1'b1;
            end
         end
         PH_SRC: begin
            if (is_dig) begin
               if (dig_ovf) err = 1'b1;
               else acc_in = dig_sum;
            end else if (word.code_byte == CH_COMMA) begin
               if (acc_ff == POS_ZERO || acc_ff > len_ff) begin
                  err = 1'b1;
               end else begin
                  src_in = acc_ff;
                  acc_in = POS_ZERO;
                  phase_in = PH_NUM;
               end
            end else begin
               err = 1'b1;
            end
         end
         PH_NUM: begin
            if (is_dig) begin
               if (dig_ovf) err = 1'b1;
               else acc_in = dig_sum;
            end else if (word.code_byte == CH_CLOSE && acc_ff != POS_ZERO) begin
               tok.token_kind = KIND_REF;
               tok.ref_source = fit32(src_ff - POS_ONE);
               tok.ref_count = fit32(acc_ff);
               tok_valid = 1'b1;
               acc_in = POS_ZERO;
               phase_in = PH_BODY;
            end else begin
               err = 1'b1;
            end
         end
         default: begin
            // error phase and unused codes swallow bytes
         end
      endcase

      if (err) begin
         tok = '0;
         tok.token_kind = KIND_ERR;
         tok_valid = 1'b1;
         phase_in = PH_ERR;
      end

      if (word.last_byte) begin
         // stream cut inside a number
         if (!tok_valid && (phase_in == PH_HDR || phase_in == PH_SRC || phase_in == PH_NUM))
         begin
            tok = '0;
            tok.token_kind = KIND_ERR;
            tok_valid = 1'b1;
         end
         phase_in = PH_HDR;
         acc_in = POS_ZERO;
         src_in = POS_ZERO;
         len_in = POS_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR;
         acc_ff   <= POS_ZERO;
         src_ff   <= POS_ZERO;
         len_ff   <= POS_ZERO;
      end else if (step) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         src_ff   <= src_in;
         len_ff   <= len_in;
      end
   end

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      step && word.last_byte |=> phase_ff == PH_HDR && acc_ff == POS_ZERO && len_ff == POS_ZERO)
      else $error("parser not back in header phase after last word");

   a_err_silent: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERR && !word.last_byte |-> !tok_valid)
      else $error("token produced in sticky error phase");

   a_ref_in_range: assert property (@(posedge clock) disable iff (reset)
      tok_valid && tok.token_kind == KIND_REF |-> src_ff != POS_ZERO && src_ff <= len_ff)
      else $error("back reference source outside text length");

endmodule

`default_nettype wire

>>> hdl/lz_reference_token_parser.sv
// top level of the lz reference token parser: input register, parser, result register
// uses lzrtp_pkg and lzrtp_parse
//
//   channel  | ports                          | direction | payload
//   req      | req_valid req_ready req_data   | in        | code_byte, last_byte
//   rsp      | rsp_valid rsp_ready rsp_data   | out       | token fields
//
// one word per cycle sustained while rsp takes tokens; a word waits in the input register
// and its token is written to the result register when the parser steps on that word
// the parser state update (times-ten accumulate and phase) sets the cycle
// synchronous reset clears both valid flags and the parse phase
// a stalled rsp holds back only words that produce a token; others still pass
`default_nettype none

module lz_reference_token_parser #(
   parameter int POSITION_BITS = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire lzrtp_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output lzrtp_pkg::rsp_type      rsp_data
);

   import lzrtp_pkg::*;

   req_type s1_ff;
   logic    s1_valid_ff, s1_valid_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff, rsp_valid_in;

   rsp_type tok;
   logic    tok_valid;
   logic    out_free;
   logic    advance;
   logic    req_fire;

   lzrtp_parse #(
      .POSITION_BITS(POSITION_BITS)
   ) u_parse (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .word     (s1_ff),
      .tok      (tok),
      .tok_valid(tok_valid)
   );

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      advance   = s1_valid_ff && (!tok_valid || out_free);
      req_ready = !s1_valid_ff || advance;
      req_fire  = req_valid && req_ready;

      if (req_fire) s1_valid_in = 1'b1;
      else if (advance) s1_valid_in = 1'b0;
      else s1_valid_in = s1_valid_ff;

      if (advance && tok_valid) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) s1_ff <= req_data;
      if (advance && tok_valid) rsp_ff <= tok;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && tok_valid && rsp_valid_ff && !rsp_ready |-> !req_ready && !advance)
      else $error("word advanced into a full result register");

   a_token_lands: assert property (@(posedge clock) disable iff (reset)
      advance && tok_valid |=> rsp_valid_ff)
      else $error("token lost on its way to the result register");

   a_word_held: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted word missing from input register");

endmodule

`default_nettype wire
